### rtl/lsd_pkg.sv
// Shared types, constants and codes of the light sensor dimmer and pulse lock.
package lsd_pkg;

    localparam int BLOCK_SIZE = 256;
    localparam int IDX_W      = $clog2(BLOCK_SIZE);
    localparam int SMP_W      = 12;
    localparam int SUM_W      = SMP_W + IDX_W;
    localparam int QUO_W      = 12;
    localparam int NUM_W      = 2 * QUO_W;
    localparam int CNT_W      = $clog2(QUO_W);
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [SMP_W-1:0] FULL_SCALE = 12'd4095;
    localparam logic [3:0]       PULSE_MAX  = 4'd15;
    localparam logic [15:0]      TICK_MAX   = 16'hFFFF;
    localparam logic [SMP_W-1:0] PCT_SCALE  = 12'd100;

    localparam logic [CFG_IDX_W-1:0] REG_DARK_FLOOR    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BRIGHT_THRESH = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RELEASE_THRESH = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT_TICKS = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PULSES_UNLOCK = 3'd4;

    typedef enum logic [1:0] {
        CMD_SAMPLE = 2'd0,
        CMD_TICK   = 2'd1,
        CMD_TOGGLE = 2'd2
    } cmd_t;

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_EVAL   = 6'b000010,
        S_MUL    = 6'b000100,
        S_DSTART = 6'b001000,
        S_DWAIT  = 6'b010000,
        S_OUT    = 6'b100000
    } state_t;

    typedef enum logic [1:0] {
        PH_MAP = 2'd0,
        PH_SQR = 2'd1,
        PH_PCT = 2'd2
    } phase_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

endpackage

### rtl/lsd_div.sv
// Restoring divider that produces one quotient bit per cycle.
module lsd_div
    import lsd_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  logic [NUM_W-1:0]  num,
    input  logic [QUO_W-1:0]  den,
    output logic [QUO_W-1:0]  quotient,
    output div_status_t       status
);

    logic [QUO_W-1:0] rem_reg, rem_next;
    logic [QUO_W-1:0] quo_reg, quo_next;
    logic [QUO_W-1:0] den_reg, den_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [QUO_W:0]   shifted;
    logic             ge;

    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(QUO_W - 1);

    assign shifted = {rem_reg, quo_reg[QUO_W-1]};
    assign ge      = shifted >= {1'b0, den_reg};

    always_comb begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            rem_next  = num[NUM_W-1:QUO_W];
            quo_next  = num[QUO_W-1:0];
            den_next  = den;
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (ge) begin
                rem_next = QUO_W'(shifted - {1'b0, den_reg});
            end else begin
                rem_next = shifted[QUO_W-1:0];
            end
            quo_next = {quo_reg[QUO_W-2:0], ge};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_LAST) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
        cnt_reg <= cnt_next;
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    assign quotient    = quo_reg;
    assign status.busy = busy_reg;
    assign status.done = done_reg;

endmodule

### rtl/light_sensor_dimmer_and_pulse_lock.sv
// Top level: sample averaging, dimmer and pulse lock sequencer with shared multiply and divide.
//
//  Channel   Direction  Handshake            Payload
//  s_        in         s_tvalid/s_tready    tuser: cmd; tdata: sample
//  m_        out        m_tvalid/m_tready    tuser: mode; tdata: result fields
//  cfg_      in         cfg_wr_en            cfg_index, cfg_wdata
//
// Ticks, toggles, unused commands and samples that do not end a block are handled in the idle state.
// A sample that ends a block goes through evaluate, then multiply and divide passes, then output:
// three passes in dimmer mode above the dark floor, one otherwise and in security mode,
// each made of the multiply, divider start and divider wait states around the 12-step divider.
// Reset is synchronous and restores the register defaults and the power-up state.
// A result waits in the output register; a new block result stalls only if it is still held.
module light_sensor_dimmer_and_pulse_lock
    import lsd_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [15:0]           s_tdata,   // [11:0] sample
    input  logic [1:0]            s_tuser,   // [1:0] cmd
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [39:0]           m_tdata,   // [11:0] average, [23:12] duty,
                                             // [30:24] power_percent, [34:31] pulse_count,
                                             // [35] locked, [36] pulse_detected,
                                             // [37] timeout_fired, [38] led_on
    output logic                  m_tuser,   // [0] mode
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(BLOCK_SIZE - 1);

    state_t            state_reg, state_next;
    phase_t            phase_reg, phase_next;
    logic [SUM_W-1:0]  sum_reg, sum_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic [SMP_W-1:0]  avg_reg, avg_next;
    logic [SMP_W-1:0]  op_a_reg, op_a_next;
    logic [SMP_W-1:0]  op_b_reg, op_b_next;
    logic [NUM_W-1:0]  prod_reg, prod_next;
    logic [SMP_W-1:0]  duty_reg, duty_next;
    logic [6:0]        pct_reg, pct_next;
    logic              det_reg, det_next;
    logic              fired_reg, fired_next;

    logic [SMP_W-1:0]  dark_reg, bright_reg, release_reg;
    logic [15:0]       tmo_reg;
    logic [3:0]        unlock_reg;

    logic              mode_reg, mode_next;
    logic              lock_reg, lock_next;
    logic [3:0]        pulse_reg, pulse_next;
    logic              active_reg, active_next;
    logic [15:0]       timeout_reg, timeout_next;
    logic              led_reg, led_next;

    logic              m_tvalid_reg, m_tvalid_next;
    logic [39:0]       m_tdata_reg, m_tdata_next;
    logic              m_tuser_reg, m_tuser_next;

    logic              sec_start, sec_active, sec_fire, sec_reached;
    logic [3:0]        sec_pulse_a, sec_pulse;
    logic [15:0]       sec_tc_a, sec_tc;
    logic [SUM_W-1:0]  sum_add;
    logic              out_free;

    logic              div_start;
    logic [QUO_W-1:0]  div_den, div_quo;
    div_status_t       div_status;

    lsd_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .num      (prod_reg),
        .den      (div_den),
        .quotient (div_quo),
        .status   (div_status)
    );

    assign div_start = (state_reg == S_DSTART);
    assign div_den   = (phase_reg == PH_MAP) ? (FULL_SCALE - dark_reg) : FULL_SCALE;
    assign sum_add   = sum_reg + SUM_W'(s_tdata[SMP_W-1:0]);
    assign out_free  = !m_tvalid_reg || m_tready;

    always_comb begin
        sec_start   = (avg_reg > bright_reg) && !active_reg;
        sec_pulse_a = pulse_reg;
        sec_tc_a    = timeout_reg;
        sec_active  = active_reg;
        if (sec_start) begin
            if (pulse_reg != PULSE_MAX) begin
                sec_pulse_a = pulse_reg + 4'd1;
            end
            sec_active = 1'b1;
            sec_tc_a   = '0;
        end else if (avg_reg < release_reg) begin
            sec_active = 1'b0;
        end
        sec_fire = (sec_pulse_a != 4'd0) && (sec_pulse_a < unlock_reg) && (sec_tc_a > tmo_reg);
        sec_pulse   = sec_fire ? 4'd0 : sec_pulse_a;
        sec_tc      = sec_fire ? 16'd0 : sec_tc_a;
        sec_reached = sec_pulse >= unlock_reg;
    end

    always_comb begin
        state_next    = state_reg;
        phase_next    = phase_reg;
        sum_next      = sum_reg;
        idx_next      = idx_reg;
        avg_next      = avg_reg;
        op_a_next     = op_a_reg;
        op_b_next     = op_b_reg;
        prod_next     = prod_reg;
        duty_next     = duty_reg;
        pct_next      = pct_reg;
        det_next      = det_reg;
        fired_next    = fired_reg;
        mode_next     = mode_reg;
        lock_next     = lock_reg;
        pulse_next    = pulse_reg;
        active_next   = active_reg;
        timeout_next  = timeout_reg;
        led_next      = led_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;

        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    unique case (cmd_t'(s_tuser))
                        CMD_SAMPLE: begin
                            if (idx_reg == IDX_LAST) begin
                                avg_next   = sum_add[SUM_W-1:IDX_W];
                                sum_next   = '0;
                                idx_next   = '0;
                                state_next = S_EVAL;
                            end else begin
                                sum_next = sum_add;
                                idx_next = idx_reg + 1'b1;
                            end
                        end
                        CMD_TICK: begin
                            if (mode_reg && lock_reg && (timeout_reg != TICK_MAX)) begin
                                timeout_next = timeout_reg + 16'd1;
                            end
                        end
                        CMD_TOGGLE: begin
                            if (!mode_reg) begin
                                mode_next    = 1'b1;
                                lock_next    = 1'b1;
                                led_next     = 1'b0;
                                pulse_next   = '0;
                                timeout_next = '0;
                                active_next  = 1'b1;
                            end else begin
                                mode_next = 1'b0;
                                led_next  = 1'b1;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_EVAL: begin
                state_next = S_MUL;
                if (!mode_reg) begin
                    det_next   = 1'b0;
                    fired_next = 1'b0;
                    if (avg_reg > dark_reg) begin
                        phase_next = PH_MAP;
                        op_a_next  = avg_reg - dark_reg;
                        op_b_next  = FULL_SCALE;
                    end else begin
                        phase_next = PH_PCT;
                        duty_next  = '0;
                        op_a_next  = '0;
                        op_b_next  = PCT_SCALE;
                    end
                end else begin
                    det_next     = sec_start;
                    fired_next   = sec_fire;
                    pulse_next   = sec_pulse;
                    active_next  = sec_active;
                    timeout_next = sec_tc;
                    if (sec_reached) begin
                        lock_next = 1'b0;
                    end
                    duty_next  = sec_reached ? FULL_SCALE : '0;
                    phase_next = PH_PCT;
                    op_a_next  = sec_reached ? FULL_SCALE : '0;
                    op_b_next  = PCT_SCALE;
                end
            end
            S_MUL: begin
                prod_next  = NUM_W'(op_a_reg) * NUM_W'(op_b_reg);
                state_next = S_DSTART;
            end
            S_DSTART: begin
                state_next = S_DWAIT;
            end
            S_DWAIT: begin
                if (div_status.done) begin
                    unique case (phase_reg)
                        PH_MAP: begin
                            op_a_next  = div_quo;
                            op_b_next  = div_quo;
                            phase_next = PH_SQR;
                            state_next = S_MUL;
                        end
                        PH_SQR: begin
                            duty_next  = div_quo;
                            op_a_next  = div_quo;
                            op_b_next  = PCT_SCALE;
                            phase_next = PH_PCT;
                            state_next = S_MUL;
                        end
                        default: begin
                            pct_next   = div_quo[6:0];
                            state_next = S_OUT;
                        end
                    endcase
                end
            end
            S_OUT: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {1'b0, led_reg, fired_reg, det_reg, lock_reg, pulse_reg,
                                     pct_reg, duty_reg, avg_reg};
                    m_tuser_next  = mode_reg;
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        avg_reg     <= avg_next;
        op_a_reg    <= op_a_next;
        op_b_reg    <= op_b_next;
        prod_reg    <= prod_next;
        duty_reg    <= duty_next;
        pct_reg     <= pct_next;
        det_reg     <= det_next;
        fired_reg   <= fired_next;
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            phase_reg    <= PH_PCT;
            sum_reg      <= '0;
            idx_reg      <= '0;
            mode_reg     <= 1'b0;
            lock_reg     <= 1'b1;
            pulse_reg    <= '0;
            active_reg   <= 1'b0;
            timeout_reg  <= '0;
            led_reg      <= 1'b1;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            phase_reg    <= phase_next;
            sum_reg      <= sum_next;
            idx_reg      <= idx_next;
            mode_reg     <= mode_next;
            lock_reg     <= lock_next;
            pulse_reg    <= pulse_next;
            active_reg   <= active_next;
            timeout_reg  <= timeout_next;
            led_reg      <= led_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dark_reg    <= 12'd930;
            bright_reg  <= 12'd2500;
            release_reg <= 12'd1500;
            tmo_reg     <= 16'd1500;
            unlock_reg  <= 4'd3;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_DARK_FLOOR:     dark_reg    <= cfg_wdata[SMP_W-1:0];
                REG_BRIGHT_THRESH:  bright_reg  <= cfg_wdata[SMP_W-1:0];
                REG_RELEASE_THRESH: release_reg <= cfg_wdata[SMP_W-1:0];
                REG_TIMEOUT_TICKS:  tmo_reg     <= cfg_wdata;
                REG_PULSES_UNLOCK:  unlock_reg  <= cfg_wdata[3:0];
                default: begin
                end
            endcase
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    a_idle_div_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_IDLE) |-> !div_status.busy)
        else $error("divider busy while the sequencer is idle");

    a_done_in_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        div_status.done |-> (state_reg == S_DWAIT))
        else $error("divider finished outside the wait state");

    a_security_duty: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |-> (m_tdata[23:12] == 12'd0 || m_tdata[23:12] == 12'd4095))
        else $error("security result with a partial duty");

    a_percent_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[30:24] <= 7'd100))
        else $error("power percentage above full");

endmodule

### tb/tb_top.sv
// Self-checking testbench for the light sensor dimmer and pulse lock block.
module tb_top
    import lsd_pkg::*;
();

    localparam logic [1:0] CMD_UNUSED     = 2'd3;
    localparam int         SETTLE_CYCLES  = 64;
    localparam int         HOLD_CYCLES    = 2500;
    localparam int         WATCHDOG_LIMIT = 10000;
    localparam int unsigned SCALE         = FULL_SCALE;

    typedef struct packed {
        logic        mode;
        logic        led_on;
        logic        timeout_fired;
        logic        pulse_detected;
        logic        locked;
        logic [3:0]  pulse_count;
        logic [6:0]  power_percent;
        logic [11:0] duty;
        logic [11:0] average;
    } report_t;

    typedef struct {
        logic [1:0]  cmd;
        logic [11:0] level;
        int          reps;
        bit          typed;
        report_t     want;
    } script_row_t;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [15:0]           s_tdata   = '0;
    logic [1:0]            s_tuser   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [39:0]           m_tdata;
    logic                  m_tuser;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    light_sensor_dimmer_and_pulse_lock DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always #5 aclk = ~aclk;

    int unsigned cfg_dark, cfg_bright, cfg_release, cfg_timeout, cfg_unlock;
    int unsigned acc_sum, acc_count, pulses, tick_count;
    bit          sec_mode, lock_closed, pulse_on, led;

    report_t     pending_reports[$];
    script_row_t script[$];
    report_t     typed_want;
    bit          typed_pending = 1'b0;

    int tx_idle_pct    = 0;
    int rx_stall_pct   = 0;
    bit hold_go        = 1'b0;
    bit hold_used      = 1'b0;
    int hold_left      = 0;
    int quiet_cycles   = 0;
    int errors         = 0;
    int items_sent     = 0;
    int reports_checked = 0;
    int pulses_seen    = 0;
    int clears_seen    = 0;
    int open_seen      = 0;

    function automatic void reset_light_state();
        cfg_dark    = 930;
        cfg_bright  = 2500;
        cfg_release = 1500;
        cfg_timeout = 1500;
        cfg_unlock  = 3;
        acc_sum     = 0;
        acc_count   = 0;
        sec_mode    = 1'b0;
        lock_closed = 1'b1;
        pulses      = 0;
        pulse_on    = 1'b0;
        tick_count  = 0;
        led         = 1'b1;
    endfunction

    function automatic void store_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned val);
        case (idx)
            REG_DARK_FLOOR:     cfg_dark    = val & 32'hFFF;
            REG_BRIGHT_THRESH:  cfg_bright  = val & 32'hFFF;
            REG_RELEASE_THRESH: cfg_release = val & 32'hFFF;
            REG_TIMEOUT_TICKS:  cfg_timeout = val & 32'hFFFF;
            REG_PULSES_UNLOCK:  cfg_unlock  = val & 32'hF;
            default: ;
        endcase
    endfunction

    function automatic void advance_light_state(input logic [1:0] cmd, input logic [11:0] smp,
                                                output report_t rep, output bit has_rep);
        int unsigned avg, mapped, duty;
        bit          det, fired;
        has_rep = 1'b0;
        rep     = '0;
        det     = 1'b0;
        fired   = 1'b0;
        mapped  = 0;
        case (cmd)
            CMD_TICK: begin
                if (sec_mode && lock_closed && tick_count < TICK_MAX)
                    tick_count++;
            end
            CMD_TOGGLE: begin
                if (!sec_mode) begin
                    sec_mode    = 1'b1;
                    lock_closed = 1'b1;
                    led         = 1'b0;
                    pulses      = 0;
                    tick_count  = 0;
                    pulse_on    = 1'b1;
                end else begin
                    sec_mode = 1'b0;
                    led      = 1'b1;
                end
            end
            CMD_SAMPLE: begin
                acc_sum += smp;
                acc_count++;
                if (acc_count == BLOCK_SIZE) begin
                    avg       = acc_sum / BLOCK_SIZE;
                    acc_sum   = 0;
                    acc_count = 0;
                    if (!sec_mode) begin
                        if (avg > cfg_dark)
                            mapped = ((avg - cfg_dark) * SCALE) / (SCALE - cfg_dark);
                        if (mapped > SCALE)
                            mapped = SCALE;
                        duty = (mapped * mapped) / SCALE;
                    end else begin
                        if (avg > cfg_bright && !pulse_on) begin
                            if (pulses < PULSE_MAX)
                                pulses++;
                            pulse_on   = 1'b1;
                            tick_count = 0;
                            det        = 1'b1;
                        end else if (avg < cfg_release) begin
                            pulse_on = 1'b0;
                        end
                        if (pulses > 0 && pulses < cfg_unlock && tick_count > cfg_timeout) begin
                            pulses     = 0;
                            tick_count = 0;
                            fired      = 1'b1;
                        end
                        if (pulses >= cfg_unlock) begin
                            lock_closed = 1'b0;
                            duty        = SCALE;
                        end else begin
                            duty = 0;
                        end
                    end
                    rep.average        = avg[11:0];
                    rep.mode           = sec_mode;
                    rep.duty           = duty[11:0];
                    rep.power_percent  = 7'((duty * 100) / SCALE);
                    rep.pulse_count    = pulses[3:0];
                    rep.locked         = lock_closed;
                    rep.pulse_detected = det;
                    rep.timeout_fired  = fired;
                    rep.led_on         = led;
                    has_rep            = 1'b1;
                end
            end
            default: ;
        endcase
    endfunction

    function automatic report_t make_report(input int avg, input bit mode, input int duty,
                                            input int pct, input int pcount, input bit locked,
                                            input bit det, input bit fired, input bit led_on);
        report_t r;
        r.average        = avg[11:0];
        r.mode           = mode;
        r.duty           = duty[11:0];
        r.power_percent  = pct[6:0];
        r.pulse_count    = pcount[3:0];
        r.locked         = locked;
        r.pulse_detected = det;
        r.timeout_fired  = fired;
        r.led_on         = led_on;
        return r;
    endfunction

    function automatic script_row_t plain_row(input logic [1:0] cmd, input int level,
                                              input int reps);
        script_row_t r;
        r.cmd   = cmd;
        r.level = level[11:0];
        r.reps  = reps;
        r.typed = 1'b0;
        r.want  = '0;
        return r;
    endfunction

    function automatic script_row_t checked_row(input int level, input report_t want);
        script_row_t r;
        r       = plain_row(CMD_SAMPLE, level, BLOCK_SIZE);
        r.typed = 1'b1;
        r.want  = want;
        return r;
    endfunction

    function automatic int field_mismatch(input string name, input int unsigned want,
                                          input int unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            return 1;
        end
        return 0;
    endfunction

    task automatic push_item(input logic [1:0] cmd, input logic [11:0] smp);
        report_t due;
        bit      has_due;
        while (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {4'd0, smp};
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        items_sent++;
        advance_light_state(cmd, smp, due, has_due);
        if (has_due) begin
            if (typed_pending) begin
                pending_reports.push_back(typed_want);
                typed_pending = 1'b0;
            end else begin
                pending_reports.push_back(due);
            end
        end
    endtask

    task automatic quiesce();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_reports.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic set_regs(input int unsigned dark, input int unsigned bright,
                            input int unsigned rel, input int unsigned timeout,
                            input int unsigned unlock);
        logic [CFG_IDX_W-1:0] idx [5];
        int unsigned          val [5];
        idx = '{REG_DARK_FLOOR, REG_BRIGHT_THRESH, REG_RELEASE_THRESH, REG_TIMEOUT_TICKS,
                REG_PULSES_UNLOCK};
        val = '{dark, bright, rel, timeout, unlock};
        for (int k = 0; k < 5; k++) begin
            cfg_wr_en <= 1'b1;
            cfg_index <= idx[k];
            cfg_wdata <= val[k][15:0];
            @(posedge aclk);
            store_reg(idx[k], val[k]);
        end
        cfg_wr_en <= 1'b0;
    endtask

    task automatic random_regs();
        int unsigned b;
        b = $urandom_range(3800, 500);
        set_regs($urandom_range(4094), b, $urandom_range(b), $urandom_range(40),
                 $urandom_range(4));
    endtask

    task automatic enter_mode(input bit want_sec);
        if (sec_mode != want_sec)
            push_item(CMD_TOGGLE, 12'($urandom_range(4095)));
    endtask

    task automatic const_block(input int level);
        for (int n = 0; n < BLOCK_SIZE; n++)
            push_item(CMD_SAMPLE, level[11:0]);
    endtask

    task automatic send_block(input int tick_div, input int toggle_div);
        int center, spread, v;
        if (toggle_div != 0 && $urandom_range(toggle_div - 1) == 0)
            push_item(CMD_TOGGLE, 12'($urandom_range(4095)));
        spread = ($urandom_range(3) == 0) ? 0 : $urandom_range(200, 1);
        case ($urandom_range(5))
            0, 1: center = (cfg_bright < 4095) ? $urandom_range(4095, cfg_bright + 1) : 4095;
            2, 3: center = (cfg_release > 0) ? $urandom_range(cfg_release - 1) : 0;
            4: begin
                case ($urandom_range(2))
                    0:       center = cfg_dark;
                    1:       center = cfg_bright;
                    default: center = cfg_release;
                endcase
                center = center + int'($urandom_range(2)) - 1;
                spread = 0;
            end
            default: begin
                center = 2048;
                spread = 2048;
            end
        endcase
        for (int n = 0; n < BLOCK_SIZE; n++) begin
            if (tick_div != 0 && $urandom_range(tick_div - 1) == 0)
                push_item(CMD_TICK, 12'($urandom_range(4095)));
            if ($urandom_range(299) == 0)
                push_item(CMD_UNUSED, 12'($urandom_range(4095)));
            if (toggle_div != 0 && $urandom_range(2999) == 0)
                push_item(CMD_TOGGLE, 12'($urandom_range(4095)));
            v = center + int'($urandom_range(2 * spread)) - spread;
            if (v < 0)
                v = 0;
            if (v > 4095)
                v = 4095;
            push_item(CMD_SAMPLE, v[11:0]);
        end
    endtask

    always @(posedge aclk) begin
        if (hold_go && !hold_used) begin
            hold_used <= 1'b1;
            hold_left <= HOLD_CYCLES;
            m_tready  <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end else begin
            m_tready <= (rx_stall_pct == 0) || ($urandom_range(99) >= rx_stall_pct);
        end
    end

    always @(posedge aclk) begin : check_results
        report_t seen, want;
        if (aresetn && m_tvalid && m_tready) begin
            seen = {m_tuser, m_tdata[38:0]};
            if (pending_reports.size() == 0) begin
                $display("%0t: result transfer with nothing expected, actual %h", $time, seen);
                errors++;
            end else begin
                want = pending_reports.pop_front();
                errors += field_mismatch("average", want.average, seen.average);
                errors += field_mismatch("mode", want.mode, seen.mode);
                errors += field_mismatch("duty", want.duty, seen.duty);
                errors += field_mismatch("power_percent", want.power_percent,
                                         seen.power_percent);
                errors += field_mismatch("pulse_count", want.pulse_count, seen.pulse_count);
                errors += field_mismatch("locked", want.locked, seen.locked);
                errors += field_mismatch("pulse_detected", want.pulse_detected,
                                         seen.pulse_detected);
                errors += field_mismatch("timeout_fired", want.timeout_fired,
                                         seen.timeout_fired);
                errors += field_mismatch("led_on", want.led_on, seen.led_on);
                errors += field_mismatch("tdata pad", 0, m_tdata[39]);
                reports_checked++;
                pulses_seen += want.pulse_detected;
                clears_seen += want.timeout_fired;
                open_seen   += !want.locked;
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || cfg_wr_en || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $time, quiet_cycles);
            $display("light_sensor_dimmer_and_pulse_lock regression: fail");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        reset_light_state();

        script.push_back(plain_row(CMD_UNUSED, 4095, 1));
        script.push_back(plain_row(CMD_TICK, 0, 3));
        script.push_back(checked_row(0, make_report(0, 0, 0, 0, 0, 1, 0, 0, 1)));
        script.push_back(checked_row(4095, make_report(4095, 0, 4095, 100, 0, 1, 0, 0, 1)));
        script.push_back(checked_row(930, make_report(930, 0, 0, 0, 0, 1, 0, 0, 1)));
        script.push_back(plain_row(CMD_SAMPLE, 2500, BLOCK_SIZE));
        script.push_back(plain_row(CMD_TOGGLE, 0, 1));
        script.push_back(checked_row(4095, make_report(4095, 1, 0, 0, 0, 1, 0, 0, 0)));
        script.push_back(checked_row(1499, make_report(1499, 1, 0, 0, 0, 1, 0, 0, 0)));
        script.push_back(plain_row(CMD_SAMPLE, 2500, BLOCK_SIZE));
        script.push_back(plain_row(CMD_SAMPLE, 2501, BLOCK_SIZE));
        script.push_back(plain_row(CMD_SAMPLE, 1500, BLOCK_SIZE));
        script.push_back(plain_row(CMD_SAMPLE, 1499, BLOCK_SIZE));
        script.push_back(plain_row(CMD_SAMPLE, 4095, BLOCK_SIZE));
        script.push_back(plain_row(CMD_TICK, 0, 1501));
        script.push_back(checked_row(0, make_report(0, 1, 0, 0, 0, 1, 0, 1, 0)));
        script.push_back(plain_row(CMD_SAMPLE, 4095, BLOCK_SIZE));
        script.push_back(plain_row(CMD_SAMPLE, 0, BLOCK_SIZE));
        script.push_back(plain_row(CMD_SAMPLE, 4095, BLOCK_SIZE));
        script.push_back(plain_row(CMD_SAMPLE, 0, BLOCK_SIZE));
        script.push_back(checked_row(4095, make_report(4095, 1, 4095, 100, 3, 0, 1, 0, 0)));
        script.push_back(plain_row(CMD_TICK, 0, 5));
        script.push_back(plain_row(CMD_TOGGLE, 0, 1));
        script.push_back(plain_row(CMD_SAMPLE, 2000, BLOCK_SIZE));
        script.push_back(plain_row(CMD_TOGGLE, 0, 1));

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (script[i]) begin
            for (int k = 0; k < script[i].reps; k++) begin
                if (script[i].typed && k == script[i].reps - 1) begin
                    typed_pending = 1'b1;
                    typed_want    = script[i].want;
                end
                push_item(script[i].cmd, script[i].level);
            end
        end
        quiesce();

        set_regs(0, 4095, 0, 0, 0);
        repeat (5) send_block(30, 3);
        quiesce();

        // The output is held back early here so the block fills and stalls its input.
        set_regs(4094, 0, 4095, 65535, 15);
        hold_go <= 1'b1;
        enter_mode(1'b1);
        repeat (36) send_block(40, 0);
        enter_mode(1'b0);
        repeat (3) send_block(40, 0);
        quiesce();

        random_regs();
        tx_idle_pct = 70;
        repeat (10) send_block(15, 5);
        quiesce();

        random_regs();
        tx_idle_pct = 0;
        rx_stall_pct <= 70;
        repeat (10) send_block(15, 5);
        quiesce();

        random_regs();
        tx_idle_pct = 28;
        rx_stall_pct <= 28;
        repeat (10) send_block(15, 5);
        quiesce();

        // The tick counter must stick at its maximum and still clear the partial count.
        set_regs(930, 2000, 1500, 65534, 15);
        tx_idle_pct = 0;
        rx_stall_pct <= 0;
        enter_mode(1'b0);
        enter_mode(1'b1);
        const_block(0);
        const_block(4095);
        repeat (65536) push_item(CMD_TICK, 12'($urandom_range(4095)));
        const_block(0);
        quiesce();

        if (pending_reports.size() != 0) begin
            $display("%0t: %0d expected results never arrived", $time, pending_reports.size());
            errors++;
        end
        $display("Checked %0d block results from %0d input transfers, %0d field mismatches.",
                 reports_checked, items_sent, errors);
        $display("Saw %0d pulses, %0d timeout clears and %0d results with the lock open.",
                 pulses_seen, clears_seen, open_seen);
        if (errors == 0) begin
            $display("light_sensor_dimmer_and_pulse_lock regression: pass");
        end else begin
            $display("light_sensor_dimmer_and_pulse_lock regression: fail");
        end
        $finish;
    end

endmodule
